>>> rtl/tait_pkg.sv
// ----------------------------------------------------------------------------
// tait_pkg
// Shared types and constants for the two-actuator interlock timers.
// ----------------------------------------------------------------------------
package tait_pkg;

  localparam int unsigned TimerW  = 16;
  localparam int unsigned PauseW  = 8;
  localparam int unsigned ErrW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 16;

  localparam logic [CfgIdxW-1:0] CfgLinkTimeout  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDriveTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPauseTicks   = 2'd2;

  localparam logic [TimerW-1:0] LinkTimeoutRst  = 16'd50;
  localparam logic [TimerW-1:0] DriveTimeoutRst = 16'd500;
  localparam logic [PauseW-1:0] PauseTicksRst   = 8'd15;

  typedef struct packed {
    logic [TimerW-1:0] link_timeout;
    logic [TimerW-1:0] drive_timeout;
    logic [PauseW-1:0] pause_ticks;
  } tait_cfg_t;

  typedef struct packed {
    logic [1:0] open_cmd;
    logic [1:0] close_cmd;
    logic [1:0] open_end;
    logic [1:0] closed_end;
    logic       reset_errors;
    logic       frame_ok;
  } tait_in_t;

  // drive order: open A, close A, open B, close B
  typedef struct packed {
    logic [3:0]     drive;
    logic [ErrW-1:0] error_flags;
  } tait_out_t;

endpackage

>>> rtl/tait_tick.sv
// ----------------------------------------------------------------------------
// tait_tick
// Timer state and per-tick interlock logic; state advances on en_i.
// ----------------------------------------------------------------------------
module tait_tick import tait_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  tait_in_t  in_i,
  input  tait_cfg_t cfg_i,
  output tait_out_t res_o
);

  logic [TimerW-1:0] link_q, link_d;
  logic [TimerW-1:0] dtmr_q [4];
  logic [TimerW-1:0] dtmr_d [4];
  logic [PauseW-1:0] cls_pause_q [2];
  logic [PauseW-1:0] cls_pause_d [2];
  logic [PauseW-1:0] opn_pause_q [2];
  logic [PauseW-1:0] opn_pause_d [2];
  logic [ErrW-1:0]   err_q, err_d;
  logic [3:0]        drv;

  always_comb begin
    logic [TimerW-1:0] lt;
    logic [TimerW-1:0] dt [4];
    logic [ErrW-1:0]   er;
    er = in_i.reset_errors ? '0 : err_q;
    lt = in_i.reset_errors ? cfg_i.link_timeout : link_q;
    for (int k = 0; k < 4; k++) begin
      dt[k] = in_i.reset_errors ? cfg_i.drive_timeout : dtmr_q[k];
    end
    if (in_i.frame_ok) begin
      lt    = cfg_i.link_timeout;
      er[0] = 1'b0;
    end
    if (lt == '0) er[0] = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (dt[k] == '0) er[k+1] = 1'b1;
    end
    for (int k = 0; k < 2; k++) begin
      drv[2*k]   = in_i.open_cmd[k] && !er[2*k+1] && !in_i.open_end[k] &&
                   (cls_pause_q[k] == '0);
      drv[2*k+1] = !in_i.open_cmd[k] && in_i.close_cmd[k] && !er[2*k+2] &&
                   !in_i.closed_end[k] && (opn_pause_q[k] == '0);
    end
    err_d  = er;
    link_d = (lt != '0) ? lt - 1'b1 : lt;
    for (int k = 0; k < 4; k++) begin
      if (!drv[k]) dtmr_d[k] = cfg_i.drive_timeout;
      else if (dt[k] != '0) dtmr_d[k] = dt[k] - 1'b1;
      else dtmr_d[k] = dt[k];
    end
    for (int k = 0; k < 2; k++) begin
      if (drv[2*k+1]) cls_pause_d[k] = cfg_i.pause_ticks;
      else if (cls_pause_q[k] != '0) cls_pause_d[k] = cls_pause_q[k] - 1'b1;
      else cls_pause_d[k] = cls_pause_q[k];
      if (drv[2*k]) opn_pause_d[k] = cfg_i.pause_ticks;
      else if (opn_pause_q[k] != '0) opn_pause_d[k] = opn_pause_q[k] - 1'b1;
      else opn_pause_d[k] = opn_pause_q[k];
    end
  end

  assign res_o.drive       = drv;
  assign res_o.error_flags = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LinkTimeoutRst;
      err_q  <= '0;
      for (int k = 0; k < 4; k++) dtmr_q[k] <= DriveTimeoutRst;
      for (int k = 0; k < 2; k++) begin
        cls_pause_q[k] <= '0;
        opn_pause_q[k] <= '0;
      end
    end else if (en_i) begin
      link_q <= link_d;
      err_q  <= err_d;
      for (int k = 0; k < 4; k++) dtmr_q[k] <= dtmr_d[k];
      for (int k = 0; k < 2; k++) begin
        cls_pause_q[k] <= cls_pause_d[k];
        opn_pause_q[k] <= opn_pause_d[k];
      end
    end
  end

  a_excl_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> !(drv[0] && drv[1])) else $error("both drives of actuator A on");

  a_excl_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> !(drv[2] && drv[3])) else $error("both drives of actuator B on");

  a_drv_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> (drv & err_d[4:1]) == 4'b0)
    else $error("drive on with its error flag set");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !in_i.reset_errors |=>
      (err_q[4:1] & $past(err_q[4:1])) == $past(err_q[4:1]))
    else $error("drive error flag dropped without reset request");

endmodule

>>> rtl/two_actuator_interlock_timers.sv
// ----------------------------------------------------------------------------
// two_actuator_interlock_timers
// Damper actuator interlock with link watchdog, drive and pause timers.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: one tick request
// m_*      out  m_tvalid/m_tready   m_tdata: drives and error flags
// cfg_*    in   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while m_tready is high; each request is
// first held in the input register and then sits in the result register until
// taken. m_tvalid rises as the request moves into the result register.
// A stalled result holds the input register, which then holds s_tready low.
// Reset loads the configuration defaults, reloads the link and drive timers and clears the pause timers.
// ----------------------------------------------------------------------------
module two_actuator_interlock_timers import tait_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid,
  output logic               s_tready,
  // [0] open_cmd_a [1] close_cmd_a [2] open_cmd_b [3] close_cmd_b
  // [4] open_end_a [5] closed_end_a [6] open_end_b [7] closed_end_b
  // [8] reset_errors [9] frame_ok
  input  logic [InW-1:0]     s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] open_drive_a [1] close_drive_a [2] open_drive_b [3] close_drive_b
  // [8:4] error_flags
  output logic [OutW-1:0]    m_tdata,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  tait_cfg_t cfg_q;
  tait_in_t  in_q, in_d;
  logic      in_vld_q;
  logic      out_vld_q;
  tait_out_t out_q, res;
  logic      adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_timeout  <= LinkTimeoutRst;
      cfg_q.drive_timeout <= DriveTimeoutRst;
      cfg_q.pause_ticks   <= PauseTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLinkTimeout:  cfg_q.link_timeout  <= cfg_wdata_i;
        CfgDriveTimeout: cfg_q.drive_timeout <= cfg_wdata_i;
        CfgPauseTicks:   cfg_q.pause_ticks   <= cfg_wdata_i[PauseW-1:0];
        default: ;
      endcase
    end
  end

  assign in_d.open_cmd     = {s_tdata[2], s_tdata[0]};
  assign in_d.close_cmd    = {s_tdata[3], s_tdata[1]};
  assign in_d.open_end     = {s_tdata[6], s_tdata[4]};
  assign in_d.closed_end   = {s_tdata[7], s_tdata[5]};
  assign in_d.reset_errors = s_tdata[8];
  assign in_d.frame_ok     = s_tdata[9];

  assign adv      = in_vld_q && (!out_vld_q || m_tready);
  assign s_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_tready) in_vld_q <= s_tvalid;
      if (adv) out_vld_q <= 1'b1;
      else if (m_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) in_q <= in_d;
    if (adv) out_q <= res;
  end

  tait_tick u_tick (
    .clk_i,
    .rst_ni,
    .en_i  (adv),
    .in_i  (in_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {{(OutW-4-ErrW){1'b0}}, out_q.error_flags, out_q.drive};

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> in_vld_q && out_vld_q && !m_tready)
    else $error("input stalled without a pending result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_tready |=> out_vld_q && $stable(out_q))
    else $error("stalled result changed");

  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q) else $error("processed request lost");

endmodule
